// ===== rtl/hsla_pkg.sv =====
// Package for the HSL saturation adjust unit: pixel and result transaction types,
// the classified item passed from front to back, and fixed widths and constants.
// No dependencies.
`default_nettype none
package hsla_pkg;

	localparam int CH_W   = 8;   // colour channel width
	localparam int SUM_W  = 9;   // mx + mn
	localparam int DIV_W  = 11;  // divider operand width, holds 6 * d
	localparam int SAT_W  = 12;  // saturation gain register width

	localparam logic [SAT_W-1:0] SAT_RESET = 12'd256;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
	} rgb_result_t;

	// Classified pixel: sum of max and min, numerators and divisors for saturation and hue
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [DIV_W-1:0] s_num;
		logic [DIV_W-1:0] s_den;
		logic [DIV_W-1:0] h_num;
		logic [DIV_W-1:0] h_den;
	} cls_item_t;

endpackage
`default_nettype wire

// ===== rtl/hsla_front.sv =====
// Front end: finds max/min of the pixel and forms the divider operands.
// Depends on hsla_pkg.
`default_nettype none
module hsla_front (
	input  wire hsla_pkg::pixel_t    pixel,
	output hsla_pkg::cls_item_t      item
);
	import hsla_pkg::*;

	logic [CH_W-1:0]  r, g, b, mx, mn, d;
	logic [SUM_W-1:0] sum;
	logic [DIV_W-1:0] k, d6;

	always_comb begin
		r   = pixel.red_in;
		g   = pixel.green_in;
		b   = pixel.blue_in;
		mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		d   = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		d6  = DIV_W'({d, 2'b00}) + DIV_W'({d, 1'b0});
		if (mx == r) begin
			if (g >= b)
				k = DIV_W'(g - b);
			else
				k = d6 - DIV_W'(b - g);
		end else if (mx == g) begin
			k = DIV_W'({d, 1'b0}) + DIV_W'(b) - DIV_W'(r);
		end else begin
			k = DIV_W'({d, 2'b00}) + DIV_W'(r) - DIV_W'(g);
		end

		item.sum = sum;
		if (d == '0) begin
			// grey: zero numerators, unit divisors give zero hue and saturation
			item.s_num = '0;
			item.s_den = DIV_W'(1);
			item.h_num = '0;
			item.h_den = DIV_W'(1);
		end else begin
			item.s_num = DIV_W'(d);
			item.s_den = (sum > SUM_W'(255)) ? DIV_W'(SUM_W'(510) - sum) : DIV_W'(sum);
			item.h_num = k;
			item.h_den = d6;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hsla_fifo.sv =====
// Short queue between front and back ends.
// Depends on hsla_pkg.
`default_nettype none
module hsla_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire hsla_pkg::cls_item_t wr_item,
	input  wire                      pop,
	output hsla_pkg::cls_item_t      rd_item,
	output logic                     empty,
	output logic                     full
);
	import hsla_pkg::*;

	localparam int AW = $clog2(DEPTH);

	cls_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (AW+1)'(DEPTH));
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH)) else $error("queue count overrun");
	no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("push into full queue");
	no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/hsla_div.sv =====
// Pipelined restoring divider: q = floor((a * 2^F + c) / b), a <= b, c < b.
// One quotient bit per stage, F+1 stages. Depends on hsla_pkg.
`default_nettype none
module hsla_div #(
	parameter int F = 16
) (
	input  wire                          clk,
	input  wire [hsla_pkg::DIV_W-1:0]    a,
	input  wire [hsla_pkg::DIV_W-1:0]    b,
	input  wire [F-1:0]                  c,
	output logic [F:0]                   q
);
	import hsla_pkg::*;

	logic [DIV_W-1:0] rem_q [F+1];
	logic [F:0]       quo_q [F+1];
	logic [DIV_W-1:0] den_q [F+1];
	logic [F-1:0]     low_q [F+1];

	always_ff @(posedge clk) begin
		rem_q[0] <= (a >= b) ? a - b : a;
		quo_q[0] <= (F+1)'(a >= b);
		den_q[0] <= b;
		low_q[0] <= c;
	end

	for (genvar i = 1; i <= F; i++) begin : g_stage
		logic [DIV_W:0] trial;
		logic           ge;
		always_comb begin
			trial = {rem_q[i-1], low_q[i-1][F-i]};
			ge    = (trial >= {1'b0, den_q[i-1]});
		end
		always_ff @(posedge clk) begin
			rem_q[i] <= ge ? DIV_W'(trial - {1'b0, den_q[i-1]}) : trial[DIV_W-1:0];
			quo_q[i] <= {quo_q[i-1][F-1:0], ge};
			den_q[i] <= den_q[i-1];
			low_q[i] <= low_q[i-1];
		end
	end

	assign q = quo_q[F];

endmodule
`default_nettype wire

// ===== rtl/hsla_back.sv =====
// Back end: divides out s and h, forms l by reciprocal multiply, scales
// saturation, rebuilds RGB. Depends on hsla_pkg, hsla_div.
`default_nettype none
module hsla_back #(
	parameter int F = 16,
	parameter int G = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire hsla_pkg::cls_item_t     item,
	input  wire [hsla_pkg::SAT_W-1:0]    sat_factor,
	output logic                         out_valid,
	output hsla_pkg::rgb_result_t        out
);
	import hsla_pkg::*;

	localparam int DIV_LAT = F + 1;
	localparam int LAT     = DIV_LAT + 5;
	localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
	localparam logic [F-1:0] THIRD = F'((64'd1 << F) / 3);

	// l = ceil(sum * 2^(F-1) / 255), split as sum * A + ceil(sum * B / 255)
	// with 2^(F-1) = 255 * A + B; the small part is divided by 255 through
	// a reciprocal exact for any 17-bit numerator.
	localparam int              LY_W    = 17;
	localparam int              LR_SH   = 25;
	localparam logic [F:0]      L_A     = (F+1)'((64'd1 << (F-1)) / 255);
	localparam logic [LY_W-1:0] L_B     = LY_W'((64'd1 << (F-1)) % 255);
	localparam logic [17:0]     L_RECIP = 18'd131587;  // ceil(2^25 / 255)

	logic [F:0]  s_div, h_div;
	logic [LAT-1:0] vld_q;
	logic [SUM_W-1:0] sum_line [DIV_LAT];

	logic [F:0]        l_base_q;
	logic [LY_W-1:0]   l_frac_q;
	logic [LY_W+17:0]  l_prod;
	logic [F:0]        l_line_q [DIV_LAT-1];

	hsla_div #(.F(F)) u_s_div (.clk(clk), .a(item.s_num), .b(item.s_den),
		.c('0), .q(s_div));
	hsla_div #(.F(F)) u_h_div (.clk(clk), .a(item.h_num), .b(item.h_den),
		.c('0), .q(h_div));

	always_ff @(posedge clk) begin
		sum_line[0] <= item.sum;
		for (int i = 1; i < DIV_LAT; i++)
			sum_line[i] <= sum_line[i-1];
	end

	// lightness: two stages, then delayed to line up with the dividers
	assign l_prod = (LY_W+18)'(l_frac_q) * (LY_W+18)'(L_RECIP);
	always_ff @(posedge clk) begin
		l_base_q    <= (F+1)'(item.sum) * L_A;
		l_frac_q    <= LY_W'(item.sum) * L_B + LY_W'(254);
		l_line_q[0] <= l_base_q + (F+1)'(l_prod >> LR_SH);
		for (int i = 1; i < DIV_LAT - 1; i++)
			l_line_q[i] <= l_line_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// s1: gain on saturation
	logic [F+SAT_W:0] gain_prod;
	logic [F:0]       sat_s1, l_s1;
	logic [F-1:0]     h_s1;
	logic             lt_s1;
	assign gain_prod = (F+SAT_W+1)'(s_div) * (F+SAT_W+1)'(sat_factor);
	always_ff @(posedge clk) begin
		sat_s1 <= ((gain_prod >> G) > (F+SAT_W+1)'(ONE)) ? ONE : (F+1)'(gain_prod >> G);
		l_s1   <= l_line_q[DIV_LAT-2];
		h_s1   <= h_div[F-1:0];
		lt_s1  <= (sum_line[DIV_LAT-1] < SUM_W'(255));
	end

	// s2: l * s
	logic [2*F+1:0] ls_prod;
	logic [F:0]     m_s2, l_s2, sat_s2;
	logic [F-1:0]   h_s2;
	logic           lt_s2;
	assign ls_prod = (2*F+2)'(l_s1) * (2*F+2)'(sat_s1);
	always_ff @(posedge clk) begin
		m_s2   <= (F+1)'(ls_prod >> F);
		l_s2   <= l_s1;
		sat_s2 <= sat_s1;
		h_s2   <= h_s1;
		lt_s2  <= lt_s1;
	end

	// s3: q, p and per-channel hue
	logic [F+1:0] q_w, l2;
	logic [F:0]   q_c, p_c;
	logic [F-1:0] tr_c, tb_c;
	logic [F:0]   tr_sum;
	always_comb begin
		q_w = lt_s2 ? (F+2)'(l_s2) + (F+2)'(m_s2)
		            : (F+2)'(l_s2) + (F+2)'(sat_s2) - (F+2)'(m_s2);
		q_c = (q_w > (F+2)'(ONE)) ? ONE : q_w[F:0];
		l2  = {l_s2, 1'b0};
		p_c = (l2 > (F+2)'(q_c)) ? (F+1)'(l2 - (F+2)'(q_c)) : '0;
		if (p_c > q_c)
			p_c = q_c;
		tr_sum = (F+1)'(h_s2) + (F+1)'(THIRD);
		tr_c   = (tr_sum >= ONE) ? F'(tr_sum - ONE) : tr_sum[F-1:0];
		tb_c   = (h_s2 >= THIRD) ? h_s2 - THIRD : F'(ONE - (F+1)'(THIRD) + (F+1)'(h_s2));
	end
	logic [F:0]   p_s3, q_s3;
	logic [F-1:0] t_s3 [3];
	always_ff @(posedge clk) begin
		p_s3    <= p_c;
		q_s3    <= q_c;
		t_s3[0] <= tr_c;
		t_s3[1] <= h_s2;
		t_s3[2] <= tb_c;
	end

	// s4/s5: piecewise tone per channel, then scale to a byte
	logic [CH_W-1:0] byte_s5 [3];
	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic [F+2:0]   t6, t3;
		logic [F:0]     x, span;
		logic [2*F+1:0] prod;
		logic [F:0]     base_s4, inc_s4;
		logic [F+1:0]   v;
		logic [F+9:0]   v255;
		logic [F+9:0]   scaled;
		always_comb begin
			t6   = (F+3)'({t_s3[ch], 2'b00}) + (F+3)'({t_s3[ch], 1'b0});
			t3   = (F+3)'({t_s3[ch], 1'b0}) + (F+3)'(t_s3[ch]);
			span = q_s3 - p_s3;
			x    = '0;
			if (t6 < (F+3)'(ONE))
				x = t6[F:0];
			else if (!t_s3[ch][F-1])
				x = '0;
			else if (t3 < (F+3)'({ONE, 1'b0}))
				x = (F+1)'((F+3)'({ONE, 2'b00}) - t6);
			prod = (2*F+2)'(span) * (2*F+2)'(x);
		end
		always_ff @(posedge clk) begin
			base_s4 <= (t6 >= (F+3)'(ONE) && !t_s3[ch][F-1]) ? q_s3 : p_s3;
			inc_s4  <= (F+1)'(prod >> F);
		end
		always_comb begin
			v      = (F+2)'(base_s4) + (F+2)'(inc_s4);
			v255   = (F+10)'({v, 8'b0}) - (F+10)'(v);
			scaled = v255 >> F;
		end
		always_ff @(posedge clk) begin
			byte_s5[ch] <= (scaled > (F+10)'(255)) ? 8'hFF : scaled[CH_W-1:0];
		end
	end

	assign out_valid     = vld_q[LAT-1];
	assign out.red_out   = byte_s5[0];
	assign out.green_out = byte_s5[1];
	assign out.blue_out  = byte_s5[2];

endmodule
`default_nettype wire

// ===== rtl/hsl_saturation_adjust_unit.sv =====
// Top level of the HSL saturation adjust unit: config register, front end,
// queue and back end. Depends on hsla_pkg, hsla_front, hsla_fifo, hsla_back.
//
// Channel   Signals                         Direction  Transaction
// pixel     start, busy, pixel              in         start & !busy
// result    result_valid, result            out        result_valid (one cycle)
// config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid & cfg_ready
//
// One pixel per clock, sustained. An accepted pixel is registered in the
// queue, then passes through the bit-per-stage dividers and the gain,
// multiply and tone stages before its result strobe.
// The back end never stalls, so the queue drains every cycle and busy only
// rises if the queue ever fills. Reset clears the queue, the valid line and
// sets sat_factor to unity gain.
`default_nettype none
module hsl_saturation_adjust_unit #(
	parameter int FRAC_BITS      = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire hsla_pkg::pixel_t        pixel,
	output logic                         result_valid,
	output hsla_pkg::rgb_result_t        result,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [hsla_pkg::SAT_W-1:0]    cfg_data
);
	import hsla_pkg::*;

	localparam int BACK_LAT = FRAC_BITS + 6;

	logic [SAT_W-1:0] sat_q;
	cls_item_t        cls_item, q_item;
	logic             push, pop, empty, full;

	// config write always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sat_q <= SAT_RESET;
		else if (cfg_valid && cfg_ready)
			sat_q <= cfg_data;
	end

	assign busy = full;
	assign push = start && !busy;
	assign pop  = !empty;  // back end takes an item every cycle

	hsla_front u_front (
		.pixel (pixel),
		.item  (cls_item)
	);

	hsla_fifo #(.DEPTH(4)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (cls_item),
		.pop     (pop),
		.rd_item (q_item),
		.empty   (empty),
		.full    (full)
	);

	hsla_back #(.F(FRAC_BITS), .G(GAIN_FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pop),
		.item       (q_item),
		.sat_factor (sat_q),
		.out_valid  (result_valid),
		.out        (result)
	);

	strobe_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		##BACK_LAT result_valid == $past(pop, BACK_LAT))
		else $error("result strobe out of step with queue pops");
	accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !empty) else $error("accepted pixel lost before queue");
	cfg_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> sat_q == $past(cfg_data)) else $error("gain write lost");

endmodule
`default_nettype wire

// ===== tb/hsla_checker.sv =====
// Checker for the HSL saturation adjust unit: watches pixel, config and result channels,
// predicts each pixel's adjusted colour and compares. Depends on hsla_pkg.
`timescale 1ns / 1ps
module hsla_checker #(
	parameter int FRAC_BITS      = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire hsla_pkg::pixel_t        pixel,
	input  wire                          result_valid,
	input  wire hsla_pkg::rgb_result_t   result,
	input  wire                          cfg_valid,
	input  wire                          cfg_ready,
	input  wire [hsla_pkg::SAT_W-1:0]    cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           pixels_seen,
	output int                           grey_results
);
	import hsla_pkg::*;

	localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
	localparam longint unsigned THIRD = ONE / 3;

	logic [SAT_W-1:0] gain;
	rgb_result_t      expected_rgb[$];

	function automatic longint unsigned tone(longint unsigned p, longint unsigned q,
			longint unsigned t);
		longint unsigned span;
		span = q - p;
		if (6 * t < ONE)
			return p + ((span * 6 * t) >> FRAC_BITS);
		if (2 * t < ONE)
			return q;
		if (3 * t < 2 * ONE)
			return p + ((span * (4 * ONE - 6 * t)) >> FRAC_BITS);
		return p;
	endfunction

	function automatic logic [CH_W-1:0] to_byte(longint unsigned v);
		longint unsigned x;
		x = (v * 255) >> FRAC_BITS;
		return (x > 255) ? 8'd255 : 8'(x);
	endfunction

	function automatic rgb_result_t adjust_saturation(pixel_t px, logic [SAT_W-1:0] g_fac);
		longint unsigned r, g, b, mx, mn, d, sum, l, h, s, k, den, q, p, tr, tb, fac;
		rgb_result_t res;
		r = 64'(px.red_in);
		g = 64'(px.green_in);
		b = 64'(px.blue_in);
		fac = 64'(g_fac);
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		d = mx - mn;
		sum = mx + mn;
		l = (sum * ONE + 509) / 510;
		h = 0;
		s = 0;
		if (d != 0) begin
			den = (sum > 255) ? 510 - sum : sum;
			s = (d * ONE) / den;
			if (mx == r)
				k = (g >= b) ? (g - b) : (6 * d - (b - g));
			else if (mx == g)
				k = 2 * d + b - r;
			else
				k = 4 * d + r - g;
			h = (k * ONE) / (6 * d);
			if (h >= ONE)
				h = ONE - 1;
		end
		s = (s * fac) >> GAIN_FRAC_BITS;
		if (s > ONE)
			s = ONE;
		if (s == 0) begin
			res.red_out   = to_byte(l);
			res.green_out = to_byte(l);
			res.blue_out  = to_byte(l);
		end else begin
			if (sum < 255)
				q = (l * (ONE + s)) >> FRAC_BITS;
			else
				q = l + s - ((l * s) >> FRAC_BITS);
			if (q > ONE)
				q = ONE;
			p = (2 * l > q) ? 2 * l - q : 0;
			if (p > q)
				p = q;
			tr = h + THIRD;
			if (tr >= ONE)
				tr -= ONE;
			tb = (h >= THIRD) ? h - THIRD : h + ONE - THIRD;
			res.red_out   = to_byte(tone(p, q, tr));
			res.green_out = to_byte(tone(p, q, h));
			res.blue_out  = to_byte(tone(p, q, tb));
		end
		return res;
	endfunction

	assign pending = expected_rgb.size();

	always @(posedge clk or negedge arst_n) begin
		rgb_result_t want;
		if (!arst_n) begin
			gain = SAT_RESET;
			expected_rgb.delete();
			fail_count = 0;
			pixels_seen = 0;
			grey_results = 0;
		end else begin
			// results first: a pixel accepted now cannot already be out
			if (result_valid) begin
				if (expected_rgb.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fail_count++;
				end else begin
					want = expected_rgb.pop_front();
					if (result.red_out != want.red_out) begin
						$display("%0t: red expected %0d actual %0d", $time,
							want.red_out, result.red_out);
						fail_count++;
					end
					if (result.green_out != want.green_out) begin
						$display("%0t: green expected %0d actual %0d", $time,
							want.green_out, result.green_out);
						fail_count++;
					end
					if (result.blue_out != want.blue_out) begin
						$display("%0t: blue expected %0d actual %0d", $time,
							want.blue_out, result.blue_out);
						fail_count++;
					end
					if (want.red_out == want.green_out && want.green_out == want.blue_out)
						grey_results++;
				end
			end
			if (start && !busy) begin
				expected_rgb.push_back(adjust_saturation(pixel, gain));
				pixels_seen++;
			end
			if (cfg_valid && cfg_ready)
				gain = cfg_data;
		end
	end
endmodule

// ===== tb/hsl_saturation_adjust_unit_tb.sv =====
// Testbench top for the HSL saturation adjust unit: clock, reset, pixel and gain stimulus,
// watchdog and verdict. Depends on hsla_pkg, hsla_checker and the unit itself.
`timescale 1ns / 1ps
module hsl_saturation_adjust_unit_tb;
	import hsla_pkg::*;

	localparam int FRAC_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int LATENCY        = FRAC_BITS + 7;
	localparam int STALL_LIMIT    = 4000;  // cycles with no transaction of any kind
	localparam int RANDOM_PIXELS  = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	pixel_t           pixel = '0;
	logic             result_valid;
	rgb_result_t      result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SAT_W-1:0] cfg_data = '0;

	int fail_count, pending, pixels_seen, grey_results;
	int quiet_cycles = 0;
	int gains_written = 0;

	always #1 clk = ~clk;

	hsl_saturation_adjust_unit #(
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	hsla_checker #(
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.pixels_seen  (pixels_seen),
		.grey_results (grey_results)
	);

	// Watchdog: any transaction on any channel resets the count
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// One pixel transaction. start is left high so back-to-back pixels need no
	// second assignment in the same step; busy is read at the falling edge where
	// it is settled, so the next rising edge is the accepting one.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		start <= 1'b1;
		pixel <= '{red_in: r, green_in: g, blue_in: b};
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until the pipe is empty. Every pixel yields a result, so an empty
	// queue of expectations means the unit is idle.
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_gain(input logic [SAT_W-1:0] g_val);
		drain();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= g_val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		gains_written++;
	endtask

	// Random pixel biased toward the awkward regions: greys, near-greys, saturated
	// primaries, channels pinned at the rails and red plus blue near the mid-lightness boundary.
	task automatic send_random_pixel;
		logic [7:0] r, g, b;
		int kind;
		kind = $urandom_range(0, 9);
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case (kind)
			0: begin
				g = r;
				b = r;
			end
			1: begin
				g = r + 8'($urandom_range(0, 2)) - 8'd1;
				b = r + 8'($urandom_range(0, 2)) - 8'd1;
			end
			2: begin
				r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			3: begin
				// sum of red and blue near the mid-lightness boundary
				r = 8'($urandom_range(100, 255));
				b = 8'd255 - r + 8'($urandom_range(0, 2)) - 8'd1;
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic random_burst_run(input int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst) send_random_pixel();
			left -= burst;
			if ($urandom_range(0, 3) != 0)
				pause_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		logic [SAT_W-1:0] gain_plan[5];
		gain_plan = '{12'd0, 12'd4095, 12'd128, 12'd600, 12'd256};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unity gain after reset
		send_pixel(8'd0,   8'd0,   8'd0);    // black
		send_pixel(8'd255, 8'd255, 8'd255);  // white
		send_pixel(8'd128, 8'd128, 8'd128);  // mid grey, achromatic
		send_pixel(8'd255, 8'd0,   8'd0);    // primaries, lightness on the boundary
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);    // secondaries
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);    // red max, blue above green: hue wraps
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd1,   8'd0,   8'd0);    // darkest chromatic
		send_pixel(8'd255, 8'd254, 8'd254);  // lightest chromatic
		send_pixel(8'd200, 8'd55,  8'd10);
		send_pixel(8'd170, 8'd85,  8'd85);
		pause_cycles(3);
		send_pixel(8'd20,  8'd40,  8'd60);
		send_pixel(8'd127, 8'd128, 8'd127);

		// Zero gain: every pixel collapses to its lightness
		write_gain(12'd0);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd10,  8'd200, 8'd90);
		send_pixel(8'd255, 8'd255, 8'd255);

		// Maximum gain: saturation product clamps at one
		write_gain(12'd4095);
		send_pixel(8'd130, 8'd120, 8'd125);
		send_pixel(8'd200, 8'd55,  8'd10);
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd1,   8'd0,   8'd2);

		// Random phases across several gain settings, one random gain among them
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 5)
				write_gain(gain_plan[ph]);
			else
				write_gain(12'($urandom));
			random_burst_run(RANDOM_PIXELS / 12);
			drain();  // sender waits for every outstanding result
			random_burst_run(RANDOM_PIXELS / 12);
		end

		drain();
		repeat (LATENCY + 5) @(posedge clk);

		$display("covered %0d pixels (%0d grey results) over %0d gain settings",
			pixels_seen, grey_results, gains_written + 1);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/hsla_pkg.sv
rtl/hsla_front.sv
rtl/hsla_fifo.sv
rtl/hsla_div.sv
rtl/hsla_back.sv
rtl/hsl_saturation_adjust_unit.sv
tb/hsla_checker.sv
tb/hsl_saturation_adjust_unit_tb.sv
